@@ hw/rtl/i2c_master_bit_engine_unit_macros.svh @@
// Assertion macros shared by the checker of the I2C master bit engine.
// No dependencies; included by files that hold concurrent assertions.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while dis is true.
`define I2CM_ASSERT_IMP(lbl, clk, dis, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ant) |-> (con)) \
        else $error("i2cm assertion failed");

// Next-cycle implication, disabled while dis is true.
`define I2CM_ASSERT_NXT(lbl, clk, dis, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ant) |=> (con)) \
        else $error("i2cm assertion failed");

`endif

@@ hw/rtl/i2cm_pkg.sv @@
// Package of the I2C master bit engine: codes, word types and defaults.
// No dependencies; used by every module of the block.
package i2cm_pkg;

    localparam int I2CM_QUEUE_DEPTH = 2;

    localparam logic [2:0] FUNC_START = 3'd0;
    localparam logic [2:0] FUNC_STOP  = 3'd1;
    localparam logic [2:0] FUNC_SEND  = 3'd2;
    localparam logic [2:0] FUNC_RECV  = 3'd3;
    localparam logic [2:0] FUNC_SACK  = 3'd4;
    localparam logic [2:0] FUNC_RACK  = 3'd5;

    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_SEND  = 3'd3;
    localparam logic [2:0] CMD_RECV  = 3'd4;
    localparam logic [2:0] CMD_SACK  = 3'd5;
    localparam logic [2:0] CMD_RACK  = 3'd6;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       rx_ack;
    } t_out_word;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       sda_in;
    } t_task_word;

endpackage

@@ hw/rtl/i2cm_front.sv @@
// Front end of the I2C master bit engine: classifies an input word into a tick task.
// Depends on i2cm_pkg.
module i2cm_front (
    input  i2cm_pkg::t_in_word   i_word,
    output i2cm_pkg::t_task_word o_task
);
    import i2cm_pkg::*;

    logic [2:0] w_cmd;

    always_comb begin
        unique case (i_word.func)
            FUNC_START: w_cmd = CMD_START;
            FUNC_STOP:  w_cmd = CMD_STOP;
            FUNC_SEND:  w_cmd = CMD_SEND;
            FUNC_RECV:  w_cmd = CMD_RECV;
            FUNC_SACK:  w_cmd = CMD_SACK;
            FUNC_RACK:  w_cmd = CMD_RACK;
            default:    w_cmd = CMD_IDLE;
        endcase
    end

    assign o_task.cmd     = i_word.cmd_valid ? w_cmd : CMD_IDLE;
    assign o_task.tx_byte = i_word.tx_byte;
    assign o_task.ack_bit = i_word.ack_bit;
    assign o_task.sda_in  = i_word.sda_in;

endmodule

@@ hw/rtl/i2cm_queue.sv @@
// Small first-in first-out queue of words held in registers.
// Depends on i2cm_pkg for the default depth.
module i2cm_queue #(
    parameter type T_WORD = logic [0:0],
    parameter int  DEPTH  = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  T_WORD i_word,
    output logic  o_full,
    input  logic  i_pop,
    output T_WORD o_word,
    output logic  o_empty
);
    import i2cm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T_WORD             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_word  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/i2cm_back.sv @@
// Back end of the I2C master bit engine: the pin phase sequencer, one phase per task.
// Depends on i2cm_pkg.
module i2cm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cm_pkg::t_task_word i_task,
    input  logic                 i_task_empty,
    output logic                 o_task_pop,
    output i2cm_pkg::t_out_word  o_res,
    output logic                 o_res_push,
    input  logic                 i_res_full
);
    import i2cm_pkg::*;

    logic [2:0] r_cmd, n_cmd;
    logic [4:0] r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_rx_byte, n_rx_byte;
    logic       r_rx_ack, n_rx_ack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    logic [2:0] w_cmd;
    logic [4:0] w_phase;
    logic [1:0] w_sub;
    logic [7:0] w_shift;
    logic       w_busy;
    logic       w_done;
    logic       w_step;

    function automatic logic [4:0] f_last_phase(input logic [2:0] cmd);
        logic [4:0] last;
        unique case (cmd)
            CMD_START: last = 5'd3;
            CMD_STOP:  last = 5'd3;
            CMD_SEND:  last = 5'd23;
            CMD_RECV:  last = 5'd16;
            default:   last = 5'd2;
        endcase
        return last;
    endfunction

    assign w_step     = !i_task_empty && !i_res_full;
    assign o_task_pop = w_step;
    assign o_res_push = w_step;

    always_comb begin
        w_cmd   = r_cmd;
        w_phase = r_phase;
        w_sub   = r_sub;
        w_shift = r_shift;
        if (r_cmd == CMD_IDLE) begin
            w_cmd   = i_task.cmd;
            w_phase = '0;
            w_sub   = '0;
            if (i_task.cmd == CMD_SEND) begin
                w_shift = i_task.tx_byte;
            end else if (i_task.cmd == CMD_SACK) begin
                w_shift = {i_task.ack_bit, 7'd0};
            end
        end
    end

    always_comb begin
        n_shift   = w_shift;
        n_sub     = w_sub;
        n_rx_byte = r_rx_byte;
        n_rx_ack  = r_rx_ack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        w_busy    = (w_cmd != CMD_IDLE);
        unique case (w_cmd)
            CMD_START: begin
                unique case (w_phase[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: n_scl = 1'b0;
                endcase
            end
            CMD_STOP: begin
                unique case (w_phase[1:0])
                    2'd0:    n_scl = 1'b0;
                    2'd1:    n_sda = 1'b0;
                    2'd2:    n_scl = 1'b1;
                    default: n_sda = 1'b1;
                endcase
            end
            CMD_SEND: begin
                unique case (w_sub)
                    2'd0: begin
                        n_sda = w_shift[7];
                        n_sub = 2'd1;
                    end
                    2'd1: begin
                        n_scl = 1'b1;
                        n_sub = 2'd2;
                    end
                    default: begin
                        n_scl   = 1'b0;
                        n_sub   = 2'd0;
                        n_shift = {w_shift[6:0], 1'b0};
                    end
                endcase
            end
            CMD_RECV: begin
                if (w_phase == 5'd0) begin
                    n_sda   = 1'b1;
                    n_shift = '0;
                end else if (w_phase[0]) begin
                    n_scl   = 1'b1;
                    n_shift = {w_shift[6:0], i_task.sda_in};
                end else begin
                    n_scl = 1'b0;
                end
            end
            CMD_SACK: begin
                if (w_phase == 5'd0) begin
                    n_sda = w_shift[7];
                end else if (w_phase == 5'd1) begin
                    n_scl = 1'b1;
                end else begin
                    n_scl = 1'b0;
                end
            end
            CMD_RACK: begin
                if (w_phase == 5'd0) begin
                    n_sda = 1'b1;
                end else if (w_phase == 5'd1) begin
                    n_scl    = 1'b1;
                    n_rx_ack = i_task.sda_in;
                end else begin
                    n_scl = 1'b0;
                end
            end
            default: begin
            end
        endcase

        w_done  = w_busy && (w_phase == f_last_phase(w_cmd));
        n_cmd   = w_cmd;
        n_phase = w_busy ? (w_phase + 5'd1) : 5'd0;
        if (w_done) begin
            if (w_cmd == CMD_RECV) begin
                n_rx_byte = n_shift;
            end
            n_cmd   = CMD_IDLE;
            n_phase = '0;
            n_sub   = '0;
        end
    end

    assign o_res.scl_out  = n_scl;
    assign o_res.sda_out  = n_sda;
    assign o_res.busy_res = w_busy;
    assign o_res.done_res = w_done;
    assign o_res.rx_byte  = n_rx_byte;
    assign o_res.rx_ack   = n_rx_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd     <= CMD_IDLE;
            r_phase   <= '0;
            r_sub     <= '0;
            r_shift   <= '0;
            r_rx_byte <= '0;
            r_rx_ack  <= 1'b1;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else if (w_step) begin
            r_cmd     <= n_cmd;
            r_phase   <= n_phase;
            r_sub     <= n_sub;
            r_shift   <= n_shift;
            r_rx_byte <= n_rx_byte;
            r_rx_ack  <= n_rx_ack;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

endmodule

@@ hw/rtl/i2c_master_bit_engine_unit.sv @@
// Top level of the I2C master bit engine: front end, task queue, sequencer, result queue.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
//
//   Channel   Handshake      Word
//   input     push / full    i_cmd (t_in_word), one bus tick per word
//   result    pop / empty    o_res (t_out_word), one result per input word
//
// One word per clock is sustained while results are taken; the sequencer advances one pin phase per clock in which
// it has a task and room for its result. A word is registered in the task queue, and its result in the result queue.
// Reset is synchronous and empties both queues and returns the bus to idle levels.
// When results are not taken, the result queue fills, then the task queue, then full rises.
module i2c_master_bit_engine_unit #(
    parameter int QUEUE_DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  i2cm_pkg::t_in_word  i_cmd,
    input  logic                pop,
    output logic                empty,
    output i2cm_pkg::t_out_word o_res
);
    import i2cm_pkg::*;

    t_task_word w_task_in;
    t_task_word w_task_out;
    t_out_word  w_res;
    logic       w_task_empty;
    logic       w_task_pop;
    logic       w_res_push;
    logic       w_res_full;

    i2cm_front u_front (
        .i_word (i_cmd),
        .o_task (w_task_in)
    );

    i2cm_queue #(
        .T_WORD (t_task_word),
        .DEPTH  (QUEUE_DEPTH)
    ) u_task_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (w_task_in),
        .o_full  (full),
        .i_pop   (w_task_pop),
        .o_word  (w_task_out),
        .o_empty (w_task_empty)
    );

    i2cm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task       (w_task_out),
        .i_task_empty (w_task_empty),
        .o_task_pop   (w_task_pop),
        .o_res        (w_res),
        .o_res_push   (w_res_push),
        .i_res_full   (w_res_full)
    );

    i2cm_queue #(
        .T_WORD (t_out_word),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_word  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_word  (o_res),
        .o_empty (empty)
    );

endmodule

@@ hw/rtl/i2cm_checker.sv @@
// Port-level checker of the I2C master bit engine, bound to the top level.
// Depends on i2cm_pkg and i2c_master_bit_engine_unit_macros.svh.
`include "i2c_master_bit_engine_unit_macros.svh"

module i2cm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input i2cm_pkg::t_in_word  i_cmd,
    input logic                pop,
    input logic                empty,
    input i2cm_pkg::t_out_word o_res
);
    import i2cm_pkg::*;

    // A command can only finish on a tick that performed a phase.
    `I2CM_ASSERT_IMP(a_done_busy, i_clk, !i_rst_n, !empty && o_res.done_res, o_res.busy_res)

    // Reset leaves no result waiting and room for input.
    `I2CM_ASSERT_NXT(a_reset_clear, i_clk, 1'b0, !i_rst_n, empty && !full)

    // A waiting result that is not taken stays on the ports.
    `I2CM_ASSERT_NXT(a_res_hold, i_clk, !i_rst_n, !empty && !pop, !empty && $stable(o_res))

    // A full task queue with nothing taken means a result will wait next cycle.
    `I2CM_ASSERT_NXT(a_full_empty, i_clk, !i_rst_n, full && !pop, !empty)

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (.*);
